// File: rtl/ale_pkg.sv
`default_nettype none

package ale_pkg;

    localparam int MAX_DEGREE_DEF = 12;
    localparam int RESULT_FRACTION_BITS_DEF = 24;

    localparam logic [63:0] BIG_MAG = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [61:0] HI_LIMIT = 62'h1FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_ORDER = 2'd1,
        STATUS_SAT   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_ROUND,
        S_SEED_INT,
        S_QHI,
        S_QLO,
        S_PINT,
        S_RINT,
        S_BINT,
        S_SUB,
        S_DIV,
        S_DIVEND,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_SEED,
        PH_PMMP,
        PH_REC
    } phase_t;

    typedef struct packed {
        logic               ov;
        logic signed [63:0] val;
    } sat_t;

    function automatic logic [62:0] mag_of(input logic signed [63:0] v);
        logic [63:0] t;
        begin
            t = v[63] ? (64'd0 - v) : v;
            return t[62:0];
        end
    endfunction

    function automatic sat_t mul_int(input logic signed [63:0] v, input logic [4:0] k);
        logic [67:0] p;
        logic [62:0] m;
        sat_t r;
        begin
            p = {5'd0, mag_of(v)} * {63'd0, k};
            if (p > {4'd0, BIG_MAG}) begin
                r.ov = 1'b1;
                m = BIG_MAG[62:0];
            end
            else begin
                r.ov = 1'b0;
                m = p[62:0];
            end
            r.val = v[63] ? (64'd0 - {1'b0, m}) : {1'b0, m};
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/associated_legendre_eval_unit.sv
// Evaluates the associated Legendre value P_l^m(x) with Condon-Shortley phase for one
// request at a time; degree and order are 4-bit, x is signed Q1.30 and the value comes
// back in signed 64-bit fixed point with RESULT_FRACTION_BITS fraction bits, saturated to
// +-(2^63-1) with status 2, or 0 with status 1 when order exceeds degree. All work runs on
// one 32x31 multiplier and a small sequencer: the seed needs x^2 (S_SQ), a bit-serial
// square root (S_ROOT) and a round step (S_ROUND), then S_SEED_INT, S_QHI and S_QLO per
// order step; P_{m+1}^m takes S_QHI, S_QLO and S_PINT, and each further upward recurrence
// step takes two multiplier passes, two small-integer scalings, a subtract and a divide by
// l-m. The block returns to idle before it takes the next request, and in_stall stays high
// from acceptance until then.
`default_nettype none

module associated_legendre_eval_unit #(
    parameter int MAX_DEGREE = ale_pkg::MAX_DEGREE_DEF,
    parameter int RESULT_FRACTION_BITS = ale_pkg::RESULT_FRACTION_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [3:0]         degree,
    input  wire logic [3:0]         order,
    input  wire logic signed [31:0] argument,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [63:0]      value,
    output logic [1:0]              status
);

    localparam logic [3:0] MAX_D = 4'(MAX_DEGREE);
    localparam logic [63:0] PMM_INIT = 64'd1 << RESULT_FRACTION_BITS;
    localparam logic signed [31:0] X_ONE = 32'sd1073741824;
    localparam logic signed [31:0] X_MONE = -32'sd1073741824;

    ale_pkg::state_t state_reg, state_next;
    ale_pkg::phase_t phase_reg, phase_next;
    ale_pkg::status_t stat_reg, stat_next;

    logic [3:0]         l_reg, l_next, m_reg, m_next;
    logic [4:0]         i_reg, i_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [31:0] x_reg, x_next;
    logic [30:0]        s_reg, s_next;
    logic [61:0]        sq_reg, sq_next;
    logic [32:0]        rem_reg, rem_next;
    logic [30:0]        root_reg, root_next;
    logic signed [63:0] pmm_reg, pmm_next, pmmp_reg, pmmp_next;
    logic signed [63:0] pll_reg, pll_next, opv_reg, opv_next, a_reg, a_next;
    logic [61:0]        hi_reg, hi_next;
    logic               ov_reg, ov_next;
    logic [63:0]        quo_reg, quo_next;
    logic [3:0]         drem_reg, drem_next;
    logic               dneg_reg, dneg_next;
    logic               out_valid_reg;
    logic signed [63:0] value_reg;
    logic [1:0]         status_reg;

    logic               accept;
    logic [3:0]         l_c, m_c;
    logic signed [31:0] x_c;
    logic [30:0]        x_mag;
    logic [62:0]        opv_mag;
    logic [30:0]        q_mag;
    logic               q_neg;
    logic [31:0]        mult_a;
    logic [30:0]        mult_b;
    logic [62:0]        mult_p;
    logic [63:0]        lo_sum;
    logic [64:0]        q_sum;
    logic               ovq;
    logic [62:0]        rq_mag;
    logic signed [63:0] rq;
    logic [4:0]         k_odd, k_mm, k_bm;
    ale_pkg::sat_t      mi_seed, mi_p, mi_r, mi_b;
    logic [34:0]        r35;
    logic [32:0]        trial;
    logic signed [64:0] diff;
    logic [3:0]         dvs;
    logic [63:0]        quo_w;
    logic [3:0]         drem_w;
    logic [4:0]         r5;
    logic [63:0]        qround;
    logic signed [63:0] qres;
    logic [60:0]        s2;
    logic               done_load;

    assign accept = in_valid && (state_reg == ale_pkg::S_IDLE);
    assign in_stall = (state_reg != ale_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign value = value_reg;
    assign status = status_reg;

    assign l_c = (degree > MAX_D) ? MAX_D : degree;
    assign m_c = (order > MAX_D) ? MAX_D : order;
    assign x_c = (argument > X_ONE) ? X_ONE : ((argument < X_MONE) ? X_MONE : argument);

    assign x_mag = x_reg[31] ? 31'(32'd0 - x_reg) : x_reg[30:0];
    assign opv_mag = ale_pkg::mag_of(opv_reg);
    assign q_mag = (phase_reg == ale_pkg::PH_SEED) ? s_reg : x_mag;
    assign q_neg = (phase_reg != ale_pkg::PH_SEED) && x_reg[31];

    always_comb
    begin
        unique case (state_reg)
            ale_pkg::S_SQ:
            begin
                mult_a = {1'b0, x_mag};
                mult_b = x_mag;
            end
            ale_pkg::S_QHI:
            begin
                mult_a = {1'b0, opv_mag[62:32]};
                mult_b = q_mag;
            end
            default:
            begin
                mult_a = opv_mag[31:0];
                mult_b = q_mag;
            end
        endcase
    end

    assign mult_p = 63'({31'd0, mult_a} * {32'd0, mult_b});
    assign s2 = (61'd1 << 60) - mult_p[60:0];

    assign lo_sum = ({1'b0, mult_p} + (64'd1 << 29)) >> 30;
    assign q_sum = {1'b0, hi_reg, 2'b00} + {1'b0, lo_sum};
    assign ovq = (hi_reg > ale_pkg::HI_LIMIT) || (q_sum > {1'b0, ale_pkg::BIG_MAG});
    assign rq_mag = ovq ? ale_pkg::BIG_MAG[62:0] : q_sum[62:0];
    assign rq = (opv_reg[63] != q_neg) ? (64'd0 - {1'b0, rq_mag}) : {1'b0, rq_mag};

    assign k_odd = {i_reg[3:0], 1'b0} - 5'd1;
    assign k_mm = {m_reg, 1'b1};
    assign k_bm = i_reg + {1'b0, m_reg} - 5'd1;
    assign mi_seed = ale_pkg::mul_int(pmm_reg, k_odd);
    assign mi_p = ale_pkg::mul_int(a_reg, k_mm);
    assign mi_r = ale_pkg::mul_int(a_reg, k_odd);
    assign mi_b = ale_pkg::mul_int(pmm_reg, k_bm);

    assign r35 = {rem_reg, sq_reg[61:60]};
    assign trial = {root_reg, 2'b01};

    assign diff = {a_reg[63], a_reg} - {opv_reg[63], opv_reg};
    assign dvs = i_reg[3:0] - m_reg;

    always_comb
    begin
        quo_w = quo_reg;
        drem_w = drem_reg;
        r5 = 5'd0;
        for (int b = 0; b < 8; b++)
        begin
            r5 = {drem_w, quo_w[63]};
            quo_w = {quo_w[62:0], (r5 >= {1'b0, dvs})};
            drem_w = (r5 >= {1'b0, dvs}) ? 4'(r5 - {1'b0, dvs}) : r5[3:0];
        end
    end

    assign qround = quo_reg + {63'd0, ({drem_reg, 1'b0} >= {1'b0, dvs})};
    assign qres = dneg_reg ? (64'd0 - qround) : qround;
    assign done_load = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (order > degree)
                        state_next = ale_pkg::S_DONE;
                    else if (m_c != 4'd0)
                        state_next = ale_pkg::S_SQ;
                    else if (l_c != 4'd0)
                        state_next = ale_pkg::S_QHI;
                    else
                        state_next = ale_pkg::S_DONE;
                end
            end
            ale_pkg::S_SQ:
                state_next = ale_pkg::S_ROOT;
            ale_pkg::S_ROOT:
                if (cnt_reg == 5'd30)
                    state_next = ale_pkg::S_ROUND;
            ale_pkg::S_ROUND:
                state_next = ale_pkg::S_SEED_INT;
            ale_pkg::S_SEED_INT:
                state_next = mi_seed.ov ? ale_pkg::S_DONE : ale_pkg::S_QHI;
            ale_pkg::S_QHI:
                state_next = ale_pkg::S_QLO;
            ale_pkg::S_QLO:
            begin
                unique case (phase_reg)
                    ale_pkg::PH_SEED:
                    begin
                        if (ovq)
                            state_next = ale_pkg::S_DONE;
                        else if (i_reg[3:0] != m_reg)
                            state_next = ale_pkg::S_SEED_INT;
                        else if (l_reg > m_reg)
                            state_next = ale_pkg::S_QHI;
                        else
                            state_next = ale_pkg::S_DONE;
                    end
                    ale_pkg::PH_PMMP:
                        state_next = ale_pkg::S_PINT;
                    default:
                        state_next = ale_pkg::S_RINT;
                endcase
            end
            ale_pkg::S_PINT:
            begin
                if (ov_reg || mi_p.ov || ({1'b0, m_reg} + 5'd2 > {1'b0, l_reg}))
                    state_next = ale_pkg::S_DONE;
                else
                    state_next = ale_pkg::S_QHI;
            end
            ale_pkg::S_RINT:
                state_next = (ov_reg || mi_r.ov) ? ale_pkg::S_DONE : ale_pkg::S_BINT;
            ale_pkg::S_BINT:
                state_next = mi_b.ov ? ale_pkg::S_DONE : ale_pkg::S_SUB;
            ale_pkg::S_SUB:
            begin
                if (diff > $signed({1'b0, ale_pkg::BIG_MAG})
                    || diff < -$signed({1'b0, ale_pkg::BIG_MAG}))
                    state_next = ale_pkg::S_DONE;
                else
                    state_next = ale_pkg::S_DIV;
            end
            ale_pkg::S_DIV:
                if (cnt_reg == 5'd7)
                    state_next = ale_pkg::S_DIVEND;
            ale_pkg::S_DIVEND:
                state_next = (i_reg[3:0] >= l_reg) ? ale_pkg::S_DONE : ale_pkg::S_QHI;
            ale_pkg::S_DONE:
                if (done_load)
                    state_next = ale_pkg::S_IDLE;
            default:
                state_next = ale_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        phase_next = phase_reg;
        stat_next = stat_reg;
        l_next = l_reg;
        m_next = m_reg;
        i_next = i_reg;
        cnt_next = cnt_reg;
        x_next = x_reg;
        s_next = s_reg;
        sq_next = sq_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        pmm_next = pmm_reg;
        pmmp_next = pmmp_reg;
        pll_next = pll_reg;
        opv_next = opv_reg;
        a_next = a_reg;
        hi_next = hi_reg;
        ov_next = ov_reg;
        quo_next = quo_reg;
        drem_next = drem_reg;
        dneg_next = dneg_reg;
        unique case (state_reg)
            ale_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    l_next = l_c;
                    m_next = m_c;
                    x_next = x_c;
                    ov_next = 1'b0;
                    i_next = 5'd1;
                    pmm_next = PMM_INIT;
                    opv_next = PMM_INIT;
                    pll_next = PMM_INIT;
                    phase_next = ale_pkg::PH_PMMP;
                    stat_next = ale_pkg::STATUS_OK;
                    if (order > degree)
                    begin
                        pll_next = 64'sd0;
                        stat_next = ale_pkg::STATUS_ORDER;
                    end
                end
            end
            ale_pkg::S_SQ:
            begin
                sq_next = {1'b0, s2};
                rem_next = 33'd0;
                root_next = 31'd0;
                cnt_next = 5'd0;
            end
            ale_pkg::S_ROOT:
            begin
                if (r35 >= {2'b00, trial})
                begin
                    rem_next = 33'(r35 - {2'b00, trial});
                    root_next = {root_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = r35[32:0];
                    root_next = {root_reg[29:0], 1'b0};
                end
                sq_next = {sq_reg[59:0], 2'b00};
                cnt_next = cnt_reg + 5'd1;
            end
            ale_pkg::S_ROUND:
            begin
                s_next = (rem_reg > {2'b00, root_reg}) ? root_reg + 31'd1 : root_reg;
                i_next = 5'd1;
            end
            ale_pkg::S_SEED_INT:
            begin
                pll_next = mi_seed.val;
                ov_next = mi_seed.ov;
                opv_next = mi_seed.val;
                phase_next = ale_pkg::PH_SEED;
            end
            ale_pkg::S_QHI:
                hi_next = mult_p[61:0];
            ale_pkg::S_QLO:
            begin
                unique case (phase_reg)
                    ale_pkg::PH_SEED:
                    begin
                        pmm_next = 64'sd0 - rq;
                        pll_next = 64'sd0 - rq;
                        opv_next = 64'sd0 - rq;
                        ov_next = ovq;
                        i_next = i_reg + 5'd1;
                        phase_next = ale_pkg::PH_PMMP;
                    end
                    default:
                    begin
                        a_next = rq;
                        ov_next = ov_reg | ovq;
                    end
                endcase
            end
            ale_pkg::S_PINT:
            begin
                pmmp_next = mi_p.val;
                pll_next = mi_p.val;
                opv_next = mi_p.val;
                ov_next = ov_reg | mi_p.ov;
                i_next = {1'b0, m_reg} + 5'd2;
                phase_next = ale_pkg::PH_REC;
            end
            ale_pkg::S_RINT:
            begin
                a_next = mi_r.val;
                pll_next = mi_r.val;
                ov_next = ov_reg | mi_r.ov;
            end
            ale_pkg::S_BINT:
            begin
                opv_next = mi_b.val;
                pll_next = 64'sd0 - mi_b.val;
                ov_next = mi_b.ov;
            end
            ale_pkg::S_SUB:
            begin
                if (diff > $signed({1'b0, ale_pkg::BIG_MAG}))
                begin
                    ov_next = 1'b1;
                    pll_next = $signed(ale_pkg::BIG_MAG);
                end
                else if (diff < -$signed({1'b0, ale_pkg::BIG_MAG}))
                begin
                    ov_next = 1'b1;
                    pll_next = 64'sd0 - $signed(ale_pkg::BIG_MAG);
                end
                quo_next = {1'b0, ale_pkg::mag_of(diff[63:0])};
                dneg_next = diff[64];
                drem_next = 4'd0;
                cnt_next = 5'd0;
            end
            ale_pkg::S_DIV:
            begin
                quo_next = quo_w;
                drem_next = drem_w;
                cnt_next = cnt_reg + 5'd1;
            end
            ale_pkg::S_DIVEND:
            begin
                pmm_next = pmmp_reg;
                pmmp_next = qres;
                pll_next = qres;
                opv_next = qres;
                i_next = i_reg + 5'd1;
            end
            ale_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ale_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            phase_reg <= ale_pkg::PH_SEED;
            stat_reg <= ale_pkg::STATUS_OK;
            ov_reg <= 1'b0;
            cnt_reg <= 5'd0;
            i_reg <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            stat_reg <= stat_next;
            ov_reg <= ov_next;
            cnt_reg <= cnt_next;
            i_reg <= i_next;
            if (state_reg == ale_pkg::S_DONE && done_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg <= l_next;
        m_reg <= m_next;
        x_reg <= x_next;
        s_reg <= s_next;
        sq_reg <= sq_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        pmm_reg <= pmm_next;
        pmmp_reg <= pmmp_next;
        pll_reg <= pll_next;
        opv_reg <= opv_next;
        a_reg <= a_next;
        hi_reg <= hi_next;
        quo_reg <= quo_next;
        drem_reg <= drem_next;
        dneg_reg <= dneg_next;
        if (state_reg == ale_pkg::S_DONE && done_load)
        begin
            value_reg <= pll_reg;
            status_reg <= ov_reg ? ale_pkg::STATUS_SAT : stat_reg;
        end
    end

    a_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ale_pkg::STATUS_ORDER) |-> (value == 64'sd0))
        else $error("order error result carries nonzero value");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ale_pkg::STATUS_SAT)
        |-> (value == $signed(ale_pkg::BIG_MAG) || value == -$signed(ale_pkg::BIG_MAG)))
        else $error("saturated result is not full scale");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block ready right after a request");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ale_pkg::S_DIV) |-> (cnt_reg < 5'd8))
        else $error("divide counter out of range");

endmodule

`default_nettype wire
